FILE: design/sliding_window_trimmed_mean_core_defines.svh
// Assertion macros used by the trimmed-mean core
`ifndef SLIDING_WINDOW_TRIMMED_MEAN_CORE_DEFINES_SVH
`define SLIDING_WINDOW_TRIMMED_MEAN_CORE_DEFINES_SVH

// check that a condition implies a consequence on the same edge
`define SWTM_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// check that a condition implies a consequence on the next edge
`define SWTM_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/swtm_pkg.sv
`default_nettype none
package swtm_pkg;
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND_RD,
		ST_FIND_CHK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_INS_RD,
		ST_INS_CHK,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_DIV,
		ST_OUT
	} state_t;

	localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;
	localparam logic [0:0] REG_TRIM_COUNT    = 1'b1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;
	localparam int SAMPLE_W = 32;
	localparam int TRIM_W = 5;
endpackage
`default_nettype wire

FILE: design/swtm_ram.sv
`default_nettype none
module swtm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: design/sliding_window_trimmed_mean_core.sv
// Work per word: sorted-window work (when the window is full, find the oldest sample and
// shift it out; then insert the new one), summing of the kept entries, a bit-serial divide
// and an output state; one word in flight at a time. A new word is taken only in idle, so
// the walks over the sorted memory, the divider and output back-pressure set the rate.
// Reset: arst_n clears control, fill count and ring pointer; memories are not cleared.
`default_nettype none
`include "sliding_window_trimmed_mean_core_defines.svh"
module sliding_window_trimmed_mean_core
	import swtm_pkg::*;
#(
	parameter int MAX_WINDOW = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                         sample_valid,
	output logic                              sample_ready,
	input  wire logic signed [SAMPLE_W-1:0]   sample,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output logic signed [SAMPLE_W-1:0]        average,
	output logic                              ready_res
);
	localparam int AW = $clog2(MAX_WINDOW);
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int SW = SAMPLE_W + AW + 1;
	localparam int DCW = $clog2(SW + 1);

	state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] len_q;
	logic [TRIM_W-1:0]     trim_q;
	logic [CW-1:0]         fill_q;
	logic [AW-1:0]         rptr_q;
	logic [CW-1:0]         m_eff;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         n_q;
	logic signed [SAMPLE_W-1:0] s_q;
	logic signed [SAMPLE_W-1:0] old_q;
	logic signed [SW-1:0]  sum_q;
	logic [SW-1:0]         rem_q;
	logic [SW-1:0]         quo_q;
	logic [SW-1:0]         den_q;
	logic [DCW-1:0]        dcnt_q;
	logic                  neg_q;
	logic                  ok_q;
	logic signed [SAMPLE_W-1:0] avg_q;
	logic                  rdy_q;
	logic                  rv_q;

	logic                  ar_we;
	logic [AW-1:0]         ar_waddr, ar_raddr;
	logic [SAMPLE_W-1:0]   ar_rdata;
	logic                  so_we;
	logic [AW-1:0]         so_waddr, so_raddr;
	logic [SAMPLE_W-1:0]   so_wdata, so_rdata;

	logic [CW:0]           m_wide;
	logic [CW:0]           k2;
	logic [CW:0]           old_wide;
	logic                  cfg_ok;
	logic [SW:0]           rem_try;
	logic [SW-1:0]         sum_mag;
	logic [CW-1:0]         kk;

	assign m_wide = (len_q == '0) ? (CW+1)'(1)
		: ((CW+1)'(len_q) > (CW+1)'(MAX_WINDOW)) ? (CW+1)'(MAX_WINDOW) : (CW+1)'(len_q);
	assign m_eff = m_wide[CW-1:0];
	assign k2 = (CW+1)'({trim_q, 1'b0});
	assign kk = CW'(trim_q);
	assign cfg_ok = k2 < m_wide;

	assign ar_we = sample_valid && sample_ready;
	assign ar_waddr = rptr_q;
	assign old_wide = (CW+1)'(rptr_q) + (CW+1)'(MAX_WINDOW) - m_wide;
	assign ar_raddr = (old_wide >= (CW+1)'(MAX_WINDOW))
		? AW'(old_wide - (CW+1)'(MAX_WINDOW)) : AW'(old_wide);

	swtm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_arrival (
		.clk(clk), .we(ar_we), .waddr(ar_waddr), .wdata(sample),
		.raddr(ar_raddr), .rdata(ar_rdata)
	);
	swtm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_sorted (
		.clk(clk), .we(so_we), .waddr(so_waddr), .wdata(so_wdata),
		.raddr(so_raddr), .rdata(so_rdata)
	);

	assign sample_ready = (state_q == ST_IDLE) && !cfg_we;
	assign result_valid = rv_q;
	assign average = avg_q;
	assign ready_res = rdy_q;
	assign sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign rem_try = {rem_q, quo_q[SW-1]} - {1'b0, den_q};

	always_comb begin
		state_d = state_q;
		so_we = 1'b0;
		so_waddr = AW'(idx_q);
		so_wdata = s_q;
		so_raddr = AW'(idx_q);
		case (state_q)
			ST_IDLE: begin
				if (sample_valid && sample_ready) begin
					state_d = (fill_q >= m_eff) ? ST_FIND_RD : ST_INS_RD;
				end
			end
			ST_FIND_RD: state_d = ST_FIND_CHK;
			ST_FIND_CHK: begin
				if ($signed(so_rdata) == old_q || idx_q + CW'(1) >= n_q) begin
					state_d = ST_SHIFT_RD;
				end else begin
					state_d = ST_FIND_RD;
				end
			end
			ST_SHIFT_RD: begin
				so_raddr = AW'(idx_q + CW'(1));
				state_d = (idx_q + CW'(1) < n_q) ? ST_SHIFT_WR : ST_INS_RD;
			end
			ST_SHIFT_WR: begin
				so_we = 1'b1;
				so_wdata = so_rdata;
				state_d = ST_SHIFT_RD;
			end
			ST_INS_RD: begin
				so_raddr = AW'(idx_q - CW'(1));
				if (idx_q == '0) begin
					so_we = 1'b1;
					state_d = ST_SUM_RD;
				end else begin
					state_d = ST_INS_CHK;
				end
			end
			ST_INS_CHK: begin
				so_we = 1'b1;
				if ($signed(so_rdata) > s_q) begin
					so_wdata = so_rdata;
					state_d = ST_INS_RD;
				end else begin
					state_d = ST_SUM_RD;
				end
			end
			ST_SUM_RD: begin
				state_d = (!ok_q || idx_q >= m_eff - kk) ? ST_DIV : ST_SUM_ACC;
			end
			ST_SUM_ACC: state_d = ST_SUM_RD;
			ST_DIV: state_d = (!ok_q || dcnt_q == '0) ? ST_OUT : ST_DIV;
			ST_OUT: if (!rv_q || result_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= CFG_DATA_W'(3);
			trim_q <= TRIM_W'(1);
			fill_q <= '0;
			rptr_q <= '0;
			rv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && state_d == ST_IDLE) begin
				rv_q <= 1'b1;
			end else if (rv_q && result_ready) begin
				rv_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == CFG_IDX_W'(REG_WINDOW_LENGTH)) begin
					len_q <= cfg_data;
					fill_q <= '0;
					rptr_q <= '0;
				end else if (cfg_index == CFG_IDX_W'(REG_TRIM_COUNT)) begin
					trim_q <= cfg_data[TRIM_W-1:0];
					fill_q <= '0;
					rptr_q <= '0;
				end
			end else if (state_q == ST_IDLE && sample_valid && sample_ready) begin
				rptr_q <= (rptr_q == AW'(MAX_WINDOW - 1)) ? '0 : AW'(rptr_q + AW'(1));
				fill_q <= (fill_q >= m_eff) ? m_eff : fill_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				s_q <= sample;
				idx_q <= '0;
				if (fill_q >= m_eff) begin
					n_q <= m_eff;
				end else begin
					n_q <= fill_q;
					idx_q <= fill_q;
				end
			end
			ST_FIND_RD: if (idx_q == '0) old_q <= $signed(ar_rdata);
			ST_FIND_CHK: begin
				if (!($signed(so_rdata) == old_q || idx_q + CW'(1) >= n_q)) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_SHIFT_RD: begin
				if (!(idx_q + CW'(1) < n_q)) idx_q <= n_q - CW'(1);
			end
			ST_SHIFT_WR: idx_q <= idx_q + CW'(1);
			ST_INS_RD: begin
				if (idx_q == '0) begin
					idx_q <= kk;
					sum_q <= '0;
					ok_q <= cfg_ok && (fill_q == m_eff);
				end
			end
			ST_INS_CHK: begin
				if ($signed(so_rdata) > s_q) begin
					idx_q <= idx_q - CW'(1);
				end else begin
					idx_q <= kk;
					sum_q <= '0;
					ok_q <= cfg_ok && (fill_q == m_eff);
				end
			end
			ST_SUM_RD: begin
				rem_q <= '0;
				quo_q <= sum_mag;
				neg_q <= sum_q[SW-1];
				den_q <= SW'(m_eff - CW'({trim_q, 1'b0}));
				dcnt_q <= DCW'(SW - 1);
			end
			ST_SUM_ACC: begin
				sum_q <= sum_q + SW'($signed(so_rdata));
				idx_q <= idx_q + CW'(1);
			end
			ST_DIV: begin
				if (rem_try[SW]) begin
					rem_q <= {rem_q[SW-2:0], quo_q[SW-1]};
					quo_q <= {quo_q[SW-2:0], 1'b0};
				end else begin
					rem_q <= rem_try[SW-1:0];
					quo_q <= {quo_q[SW-2:0], 1'b1};
				end
				dcnt_q <= dcnt_q - DCW'(1);
			end
			ST_OUT: begin
				if (state_d == ST_IDLE) begin
					rdy_q <= ok_q;
					avg_q <= ok_q ? (neg_q ? SAMPLE_W'(-quo_q) : SAMPLE_W'(quo_q)) : '1;
				end
			end
			default: ;
		endcase
	end

	`SWTM_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !sample_ready, "accept while busy")
	`SWTM_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= m_eff || $past(cfg_we), "fill above window")
	`SWTM_ASSERT_IMP(a_not_ready_avg, clk, arst_n, rv_q && !rdy_q, avg_q == '1, "not ready but average set")
	`SWTM_ASSERT_NEXT(a_out_hold, clk, arst_n, rv_q && !result_ready, rv_q && $stable(avg_q), "result dropped")
endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import swtm_pkg::*;

	localparam int WIN_MAX = 64;
	localparam int IDLE_GAP = 400;
	localparam int CYCLE_LIMIT = 4000000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] avg;
		logic                       rdy;
	} mean_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] s;
		bit                         typed;
		logic signed [SAMPLE_W-1:0] avg;
		bit                         rdy;
	} row_t;

	typedef struct {
		logic [CFG_DATA_W-1:0] len;
		logic [CFG_DATA_W-1:0] trim;
		bit                    spare_only;
		int                    n;
		bit                    no_gaps;
		bit                    long_hold;
	} phase_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       sample_valid;
	logic                       sample_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       result_valid;
	logic                       result_ready;
	logic signed [SAMPLE_W-1:0] average;
	logic                       ready_res;

	sliding_window_trimmed_mean_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready),
		.average(average), .ready_res(ready_res)
	);

	// window copy kept alongside the block
	logic [6:0]                 win_len;
	logic [TRIM_W-1:0]          trim;
	logic signed [SAMPLE_W-1:0] ring [WIN_MAX];
	logic signed [SAMPLE_W-1:0] ordered [WIN_MAX];
	int unsigned                fill;
	int unsigned                wr_ptr;

	mean_t mean_q [$];
	mean_t typed_q [$];
	bit    typed_flag_q [$];

	int    errors = 0;
	int    cycles = 0;
	bit    no_gaps = 0;
	bit    hold_req = 0;
	bit    hold_seen = 0;
	int    hold_left = 0;
	int    stall_left = 0;
	logic signed [SAMPLE_W-1:0] last_s = 0;

	row_t dir_tab [20] = '{
		'{32'sh7fffffff, 1, -32'sd1, 0},
		'{32'sh80000000, 1, -32'sd1, 0},
		'{32'sh00000000, 1, 32'sd0, 1},
		'{32'sh7fffffff, 0, 0, 0},
		'{32'sh7fffffff, 1, 32'sh7fffffff, 1},
		'{32'sh80000000, 0, 0, 0},
		'{32'sh80000000, 0, 0, 0},
		'{32'sh80000000, 1, 32'sh80000000, 1},
		'{-32'sd1, 0, 0, 0},
		'{32'sd1, 0, 0, 0},
		'{-32'sd3, 0, 0, 0},
		'{32'sd5, 0, 0, 0},
		'{32'sd5, 0, 0, 0},
		'{32'sd5, 1, 32'sd5, 1},
		'{32'sh55555555, 0, 0, 0},
		'{32'shaaaaaaaa, 0, 0, 0},
		'{32'sd12345, 0, 0, 0},
		'{-32'sd7, 0, 0, 0},
		'{-32'sd7, 0, 0, 0},
		'{32'sd2, 0, 0, 0}
	};

	phase_t phases [15] = '{
		'{7'd0, 7'd0, 0, 40, 0, 0},
		'{7'd127, 7'd1, 0, 40, 0, 0},
		'{7'd64, 7'd31, 0, 40, 0, 0},
		'{7'd64, 7'd0, 0, 40, 1, 0},
		'{7'd1, 7'd0, 0, 40, 0, 0},
		'{7'd2, 7'd1, 0, 40, 0, 0},
		'{7'd4, 7'd2, 0, 40, 0, 0},
		'{7'd5, 7'd2, 0, 150, 0, 0},
		'{7'd3, 7'h61, 0, 150, 1, 0},
		'{7'd10, 7'd3, 0, 200, 0, 1},
		'{7'd0, 7'd0, 1, 100, 0, 0},
		'{7'd7, 7'd0, 0, 200, 0, 0},
		'{7'd20, 7'd4, 0, 200, 0, 0},
		'{7'd33, 7'd16, 0, 150, 0, 0},
		'{7'd3, 7'd1, 0, 200, 0, 0}
	};

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic mean_t trimmed_mean(input logic signed [SAMPLE_W-1:0] s);
		int unsigned m;
		int unsigned k;
		int unsigned i;
		int unsigned old;
		logic signed [SAMPLE_W-1:0] gone;
		longint sum;
		mean_t r;
		m = (win_len == 0) ? 1 : (win_len > WIN_MAX) ? WIN_MAX : win_len;
		k = trim;
		if (fill == m) begin
			old = (wr_ptr + WIN_MAX - m) % WIN_MAX;
			gone = ring[old];
			i = 0;
			while (i < fill && ordered[i] != gone)
				i++;
			for (; i + 1 < fill; i++)
				ordered[i] = ordered[i + 1];
			fill--;
		end
		i = fill;
		while (i > 0 && ordered[i - 1] > s) begin
			ordered[i] = ordered[i - 1];
			i--;
		end
		ordered[i] = s;
		fill++;
		ring[wr_ptr] = s;
		wr_ptr = (wr_ptr + 1) % WIN_MAX;
		if (fill == m && 2 * k < m) begin
			sum = 0;
			for (i = k; i < m - k; i++)
				sum += longint'(ordered[i]);
			r.avg = SAMPLE_W'(sum / longint'(m - 2 * k));
			r.rdy = 1'b1;
		end else begin
			r.avg = -32'sd1;
			r.rdy = 1'b0;
		end
		return r;
	endfunction

	// accept side: predict every word taken by the block
	always @(posedge clk) begin
		mean_t e;
		bit typed;
		mean_t tv;
		if (arst_n && sample_valid && sample_ready) begin
			e = trimmed_mean(sample);
			typed = typed_flag_q.pop_front();
			tv = typed_q.pop_front();
			mean_q.push_back(typed ? tv : e);
		end
	end

	// result side: back-pressure (random, long holds, or none) and checking
	always @(posedge clk) begin
		mean_t e;
		int r;
		cycles <= cycles + 1;
		if (arst_n && result_valid && result_ready) begin
			if (mean_q.size() == 0) begin
				$display("%0t: unexpected word avg=%0d rdy=%0b", $time, average, ready_res);
				errors++;
			end else begin
				e = mean_q.pop_front();
				if (average !== e.avg) begin
					$display("%0t: average expected %0d got %0d", $time, e.avg, average);
					errors++;
				end
				if (ready_res !== e.rdy) begin
					$display("%0t: ready_res expected %0b got %0b", $time, e.rdy, ready_res);
					errors++;
				end
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 600;
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else if (no_gaps) begin
			result_ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				result_ready <= 1'b1;
			end else begin
				stall_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
				result_ready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input bit typed,
			input mean_t tv);
		int r;
		int gap;
		typed_flag_q.push_back(typed);
		typed_q.push_back(tv);
		sample_valid <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (!sample_ready);
		r = $urandom_range(0, 99);
		gap = (no_gaps || r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain;
		sample_valid <= 1'b0;
		while (mean_q.size() != 0 || typed_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic set_config(input phase_t p);
		if (!p.spare_only) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(REG_WINDOW_LENGTH);
			cfg_data <= p.len;
			@(posedge clk);
			cfg_index <= CFG_IDX_W'(REG_TRIM_COUNT);
			cfg_data <= p.trim;
			@(posedge clk);
			win_len = p.len;
			trim = p.trim[TRIM_W-1:0];
			fill = 0;
			wr_ptr = 0;
		end
		cfg_we <= 1'b1;
		cfg_index <= REG_SPARE_LO;
		cfg_data <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_index <= REG_SPARE_HI;
		cfg_data <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample;
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2, 3: return $urandom;
			4, 5: return $signed($urandom_range(0, 16)) - 8;
			6: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
			7: return last_s;
			default: return $signed($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	initial begin
		mean_t tv;
		logic signed [SAMPLE_W-1:0] s;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_valid = 1'b0;
		sample = '0;
		result_ready = 1'b0;
		win_len = 7'd3;
		trim = 5'd1;
		fill = 0;
		wr_ptr = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			tv.avg = dir_tab[i].avg;
			tv.rdy = dir_tab[i].rdy;
			send_word(dir_tab[i].s, dir_tab[i].typed, tv);
		end
		foreach (phases[p]) begin
			drain();
			set_config(phases[p]);
			no_gaps = phases[p].no_gaps;
			for (int i = 0; i < phases[p].n; i++) begin
				if (phases[p].long_hold && i == 20)
					hold_req = !hold_req;
				s = pick_sample();
				last_s = s;
				send_word(s, 0, tv);
			end
		end
		sample_valid <= 1'b0;
		while (mean_q.size() != 0 || typed_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
